FILE: rtl/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// shared constants for the polyline circle crossings core and its units
// ----------------------------------------------------------------------------
`default_nettype none

package pcc_pkg;

  // shared multiplier: unsigned operands, one 4-bit digit of b per cycle
  localparam int MUL_W     = 68;
  localparam int MUL_DIG   = 4;
  localparam int MUL_STEPS = MUL_W / MUL_DIG;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);
  localparam int PROD_W    = 2 * MUL_W;

  // shared square root: one result bit per cycle
  localparam int SQ_RAD_W  = 128;
  localparam int SQ_ROOT_W = SQ_RAD_W / 2;
  localparam int SQ_REM_W  = SQ_ROOT_W + 3;
  localparam int SQ_CNT_W  = $clog2(SQ_ROOT_W + 1);

  // arc length
  localparam int ARC_W = 40;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_ID     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ARC_TOL      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MERGE_DIST   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_SLACK   = 3'd6;

  // configuration reset values
  localparam logic [30:0] RADIUS_RESET     = 31'd65536;
  localparam logic [15:0] ARC_TOL_RESET    = 16'd7;
  localparam logic [31:0] MERGE_DIST_RESET = 32'd4295;

endpackage

`default_nettype wire

FILE: rtl/pcc_mul.sv
// ----------------------------------------------------------------------------
// pcc_mul
// iterative unsigned multiplier, msb-first radix-16 shift and add
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_mul (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pcc_pkg::MUL_W-1:0] a,
  input  logic [pcc_pkg::MUL_W-1:0] b,
  output logic                      done,
  output logic [pcc_pkg::PROD_W-1:0] prod
);

  logic [pcc_pkg::MUL_W-1:0]     a_reg;
  logic [pcc_pkg::MUL_W-1:0]     b_reg;
  logic [pcc_pkg::MUL_CNT_W-1:0] cnt;
  logic                          busy;
  logic [pcc_pkg::MUL_W+pcc_pkg::MUL_DIG-1:0] part;

  // one digit of b times a
  assign part = (pcc_pkg::MUL_W + pcc_pkg::MUL_DIG)'(a_reg)
              * (pcc_pkg::MUL_W + pcc_pkg::MUL_DIG)'(
                  b_reg[pcc_pkg::MUL_W-1 -: pcc_pkg::MUL_DIG]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_reg <= a;
        b_reg <= b;
        prod  <= '0;
        cnt   <= pcc_pkg::MUL_CNT_W'(pcc_pkg::MUL_STEPS);
        busy  <= 1'b1;
      end else if (busy) begin
        prod  <= (prod << pcc_pkg::MUL_DIG) + pcc_pkg::PROD_W'(part);
        b_reg <= b_reg << pcc_pkg::MUL_DIG;
        cnt   <= cnt - 1'b1;
        if (cnt == pcc_pkg::MUL_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pcc_sqrt.sv
// ----------------------------------------------------------------------------
// pcc_sqrt
// iterative floor square root, one root bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pcc_pkg::SQ_RAD_W-1:0]  rad,
  output logic                          done,
  output logic [pcc_pkg::SQ_ROOT_W-1:0] root
);

  logic [pcc_pkg::SQ_RAD_W-1:0] rad_sh;
  logic [pcc_pkg::SQ_REM_W-1:0] rem;
  logic [pcc_pkg::SQ_REM_W-1:0] rem_sh;
  logic [pcc_pkg::SQ_REM_W-1:0] trial;
  logic [pcc_pkg::SQ_CNT_W-1:0] cnt;
  logic                         busy;
  logic                         ge;

  // bring down two radicand bits, try root*4+1
  assign rem_sh = {rem[pcc_pkg::SQ_REM_W-3:0], rad_sh[pcc_pkg::SQ_RAD_W-1 -: 2]};
  assign trial  = pcc_pkg::SQ_REM_W'({root, 2'b01});
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad_sh <= rad;
        rem    <= '0;
        root   <= '0;
        cnt    <= pcc_pkg::SQ_CNT_W'(pcc_pkg::SQ_ROOT_W);
        busy   <= 1'b1;
      end else if (busy) begin
        rad_sh <= rad_sh << 2;
        rem    <= ge ? rem_sh - trial : rem_sh;
        root   <= {root[pcc_pkg::SQ_ROOT_W-2:0], ge};
        cnt    <= cnt - 1'b1;
        if (cnt == pcc_pkg::SQ_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/polyline_circle_crossings_core.sv
// ----------------------------------------------------------------------------
// polyline_circle_crossings_core
// ground-plane circle crossings along a polyline, one segment at a time
// ----------------------------------------------------------------------------
// usage:
//   configuration beats (cfg_valid/cfg_ready, always ready) set the circle,
//   curve id and merge limits; write them only while the core is idle.
//   input beats carry one segment (3d endpoints, signed q15.16) and are taken
//   when in_valid is high and in_stall low. in_stall is high from the beat
//   until every hit of that segment has been taken.
//   each segment gives 0, 1 or 2 hit beats on the output side; last_of_run
//   marks the final hit of a segment. out_stall holds the hit register and
//   the sequencer waits on it.
// sequencing:
//   one segment is worked by a small sequencer on one shared multiplier
//   and one shared square root, which set how long a segment takes; output
//   stall time adds to that.
// reset:
//   synchronous rst restores the configuration defaults and clears the arc
//   length, segment counter and hit memory.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_circle_crossings_core #(
  parameter int FRAC_BITS          = 16,
  parameter int SEGMENT_INDEX_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  // segment input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [31:0]            start_x,
  input  logic signed [31:0]            start_y,
  input  logic signed [31:0]            start_z,
  input  logic signed [31:0]            end_x,
  input  logic signed [31:0]            end_y,
  input  logic signed [31:0]            end_z,
  input  logic                          first_of_curve,
  // hit output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    hit_curve,
  output logic [SEGMENT_INDEX_BITS-1:0] hit_segment,
  output logic [FRAC_BITS:0]            hit_t,
  output logic [pcc_pkg::ARC_W-1:0]     hit_arc,
  output logic signed [31:0]            hit_x,
  output logic signed [31:0]            hit_y,
  output logic signed [31:0]            hit_z,
  output logic                          last_of_run
);

  localparam int MW  = pcc_pkg::MUL_W;
  localparam int PW  = pcc_pkg::PROD_W;
  localparam int AW  = pcc_pkg::ARC_W;
  localparam int TW  = FRAC_BITS + 1;
  localparam int DCW = $clog2(FRAC_BITS + 1);

  // sequencer states
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_MUL      = 4'd1;
  localparam logic [3:0] ST_SQRT_LEN = 4'd2;
  localparam logic [3:0] ST_SQRT_S   = 4'd3;
  localparam logic [3:0] ST_CAND     = 4'd4;
  localparam logic [3:0] ST_DIV      = 4'd5;
  localparam logic [3:0] ST_MERGE    = 4'd6;
  localparam logic [3:0] ST_KEEP     = 4'd7;
  localparam logic [3:0] ST_EMIT     = 4'd8;
  localparam logic [3:0] ST_NEXT     = 4'd9;
  localparam logic [3:0] ST_DONE     = 4'd10;
  localparam logic [3:0] ST_FLUSH    = 4'd11;

  // multiplier jobs
  localparam logic [4:0] OP_DXX  = 5'd0;
  localparam logic [4:0] OP_DZZ  = 5'd1;
  localparam logic [4:0] OP_DYY  = 5'd2;
  localparam logic [4:0] OP_DOTX = 5'd3;
  localparam logic [4:0] OP_DOTZ = 5'd4;
  localparam logic [4:0] OP_CRA  = 5'd5;
  localparam logic [4:0] OP_CRB  = 5'd6;
  localparam logic [4:0] OP_CM2  = 5'd7;
  localparam logic [4:0] OP_R2   = 5'd8;
  localparam logic [4:0] OP_LIM  = 5'd9;
  localparam logic [4:0] OP_RL   = 5'd10;
  localparam logic [4:0] OP_TLO  = 5'd11;
  localparam logic [4:0] OP_THI  = 5'd12;
  localparam logic [4:0] OP_ARC  = 5'd13;
  localparam logic [4:0] OP_PX   = 5'd14;
  localparam logic [4:0] OP_PY   = 5'd15;
  localparam logic [4:0] OP_PZ   = 5'd16;
  localparam logic [4:0] OP_QX   = 5'd17;
  localparam logic [4:0] OP_QY   = 5'd18;
  localparam logic [4:0] OP_QZ   = 5'd19;

  localparam logic [TW-1:0] T_ONE = TW'(1) << FRAC_BITS;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  // configuration registers
  logic signed [31:0] center_x;
  logic signed [31:0] center_z;
  logic [30:0]        radius;
  logic [7:0]         curve_id;
  logic [15:0]        arc_tolerance;
  logic [31:0]        merge_dist_sq;
  logic [15:0]        edge_slack;

  // curve state
  logic [AW-1:0]                 arc_prefix;
  logic [SEGMENT_INDEX_BITS-1:0] segment_count;
  logic                          prev_hit_valid;
  logic [AW-1:0]                 prev_hit_arc;
  logic signed [31:0]            prev_hit_x;
  logic signed [31:0]            prev_hit_y;
  logic signed [31:0]            prev_hit_z;

  // segment work registers
  logic [3:0]          state;
  logic [4:0]          op;
  logic signed [31:0]  sx, sy, sz;
  logic signed [32:0]  dx, dy, dz;
  logic signed [32:0]  ox, oz;
  logic [65:0]         l2;
  logic [65:0]         acc3;
  logic [33:0]         len;
  logic signed [67:0]  dot;
  logic signed [67:0]  crs;
  logic [127:0]        c2;
  logic [61:0]         r2;
  logic [63:0]         sq;
  logic                kk;
  logic signed [69:0]  n;
  logic [TW-1:0]       t;
  logic [66:0]         div_rem;
  logic [DCW-1:0]      div_cnt;
  logic [AW-1:0]       arc;
  logic signed [31:0]  px, py, pz;
  logic [67:0]         d2;
  logic                pend;

  // shared units
  logic [MW-1:0] mul_a, mul_b;
  logic          mul_start, mul_done, mul_neg;
  logic [PW-1:0] mul_p;
  logic [pcc_pkg::SQ_RAD_W-1:0]  sqrt_rad;
  logic                          sqrt_start, sqrt_done;
  logic [pcc_pkg::SQ_ROOT_W-1:0] sqrt_root;

  pcc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  pcc_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .rad   (sqrt_rad),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  // datapath around the multiplier result
  logic signed [67:0]  sprod;
  logic signed [67:0]  cr_full;
  logic [67:0]         cm_abs;
  logic [127:0]        len_rad;
  logic [127:0]        rl_sub;
  logic signed [69:0]  n_cand;
  logic [69:0]         n_mag;
  logic [PW-1:0]       n_sh;
  logic [40:0]         arc_sum;
  logic [40:0]         pre_sum;
  logic signed [67:0]  lerp_q;
  logic signed [33:0]  lerp_sum;
  logic [66:0]         rem_sh;
  logic                div_ge;
  logic [TW-1:0]       t_div;
  logic [AW-1:0]       da;
  logic signed [32:0]  qx, qy, qz;
  logic [67:0]         d2_sum;
  logic                out_take;

  always_comb begin
    sprod    = mul_neg ? -$signed(mul_p[67:0]) : $signed(mul_p[67:0]);
    cr_full  = crs - sprod;
    cm_abs   = cr_full[67] ? 68'(-cr_full) : 68'(cr_full);
    len_rad  = 128'(acc3) + 128'(mul_p[65:0]);
    rl_sub   = (mul_p[127:0] > c2) ? mul_p[127:0] - c2 : '0;
    n_cand   = kk ? 70'(dot) + 70'(sq) : 70'(dot) - 70'(sq);
    n_mag    = n[69] ? 70'(-n) : 70'(n);
    n_sh     = PW'(n_mag) << FRAC_BITS;
    arc_sum  = {1'b0, arc_prefix} + 41'(mul_p >> FRAC_BITS);
    pre_sum  = {1'b0, arc_prefix} + 41'(len);
    lerp_q   = sprod >>> FRAC_BITS;
    rem_sh   = {div_rem[65:0], 1'b0};
    div_ge   = rem_sh >= 67'(l2);
    t_div    = {t[TW-2:0], div_ge};
    da       = (arc > prev_hit_arc) ? arc - prev_hit_arc : prev_hit_arc - arc;
    qx       = 33'(px) - 33'(prev_hit_x);
    qy       = 33'(py) - 33'(prev_hit_y);
    qz       = 33'(pz) - 33'(prev_hit_z);
    d2_sum   = d2 + mul_p[67:0];
    // lerp base for the coordinate being worked
    unique case (op)
      OP_PY:   lerp_sum = 34'(sy) + lerp_q[33:0];
      OP_PZ:   lerp_sum = 34'(sz) + lerp_q[33:0];
      default: lerp_sum = 34'(sx) + lerp_q[33:0];
    endcase
  end

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign out_take  = out_valid && !out_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_z      <= '0;
      radius        <= pcc_pkg::RADIUS_RESET;
      curve_id      <= '0;
      arc_tolerance <= pcc_pkg::ARC_TOL_RESET;
      merge_dist_sq <= pcc_pkg::MERGE_DIST_RESET;
      edge_slack    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pcc_pkg::CFG_CENTER_X:   center_x      <= cfg_data;
        pcc_pkg::CFG_CENTER_Z:   center_z      <= cfg_data;
        pcc_pkg::CFG_RADIUS:     radius        <= cfg_data[30:0];
        pcc_pkg::CFG_CURVE_ID:   curve_id      <= cfg_data[7:0];
        pcc_pkg::CFG_ARC_TOL:    arc_tolerance <= cfg_data[15:0];
        pcc_pkg::CFG_MERGE_DIST: merge_dist_sq <= cfg_data;
        pcc_pkg::CFG_EDGE_SLACK: edge_slack    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // segment sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      op             <= OP_DXX;
      mul_start      <= 1'b0;
      sqrt_start     <= 1'b0;
      out_valid      <= 1'b0;
      pend           <= 1'b0;
      arc_prefix     <= '0;
      segment_count  <= '0;
      prev_hit_valid <= 1'b0;
      prev_hit_arc   <= '0;
      prev_hit_x     <= '0;
      prev_hit_y     <= '0;
      prev_hit_z     <= '0;
    end else begin
      mul_start  <= 1'b0;
      sqrt_start <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            sx <= start_x;
            sy <= start_y;
            sz <= start_z;
            dx <= 33'(end_x) - 33'(start_x);
            dy <= 33'(end_y) - 33'(start_y);
            dz <= 33'(end_z) - 33'(start_z);
            ox <= 33'(center_x) - 33'(start_x);
            oz <= 33'(center_z) - 33'(start_z);
            if (first_of_curve) begin
              arc_prefix     <= '0;
              segment_count  <= '0;
              prev_hit_valid <= 1'b0;
            end
            mul_a     <= MW'(mag33(33'(end_x) - 33'(start_x)));
            mul_b     <= MW'(mag33(33'(end_x) - 33'(start_x)));
            mul_neg   <= 1'b0;
            op        <= OP_DXX;
            mul_start <= 1'b1;
            state     <= ST_MUL;
          end
        end

        ST_MUL: begin
          if (mul_done) begin
            case (op)
              OP_DXX: begin
                l2        <= mul_p[65:0];
                acc3      <= mul_p[65:0];
                mul_a     <= MW'(mag33(dz));
                mul_b     <= MW'(mag33(dz));
                op        <= OP_DZZ;
                mul_start <= 1'b1;
              end
              OP_DZZ: begin
                l2        <= l2 + mul_p[65:0];
                acc3      <= acc3 + mul_p[65:0];
                mul_a     <= MW'(mag33(dy));
                mul_b     <= MW'(mag33(dy));
                op        <= OP_DYY;
                mul_start <= 1'b1;
              end
              OP_DYY: begin
                sqrt_rad   <= len_rad;
                sqrt_start <= 1'b1;
                state      <= ST_SQRT_LEN;
              end
              OP_DOTX: begin
                dot       <= sprod;
                mul_a     <= MW'(mag33(oz));
                mul_b     <= MW'(mag33(dz));
                mul_neg   <= oz[32] ^ dz[32];
                op        <= OP_DOTZ;
                mul_start <= 1'b1;
              end
              OP_DOTZ: begin
                dot       <= dot + sprod;
                mul_a     <= MW'(mag33(ox));
                mul_b     <= MW'(mag33(dz));
                mul_neg   <= ox[32] ^ dz[32];
                op        <= OP_CRA;
                mul_start <= 1'b1;
              end
              OP_CRA: begin
                crs       <= sprod;
                mul_a     <= MW'(mag33(oz));
                mul_b     <= MW'(mag33(dx));
                mul_neg   <= oz[32] ^ dx[32];
                op        <= OP_CRB;
                mul_start <= 1'b1;
              end
              OP_CRB: begin
                // cross product beyond 64 bits: no crossing
                if (cm_abs[67:64] != '0) begin
                  state <= ST_DONE;
                end else begin
                  mul_a     <= cm_abs;
                  mul_b     <= cm_abs;
                  mul_neg   <= 1'b0;
                  op        <= OP_CM2;
                  mul_start <= 1'b1;
                end
              end
              OP_CM2: begin
                c2        <= mul_p[127:0];
                mul_a     <= MW'(radius);
                mul_b     <= MW'(radius);
                op        <= OP_R2;
                mul_start <= 1'b1;
              end
              OP_R2: begin
                r2        <= mul_p[61:0];
                mul_a     <= MW'(mul_p[61:0]) + MW'(edge_slack);
                mul_b     <= MW'(l2);
                op        <= OP_LIM;
                mul_start <= 1'b1;
              end
              OP_LIM: begin
                // miss test against (r^2 + slack) * L2
                if (c2 > mul_p[127:0]) begin
                  state <= ST_DONE;
                end else begin
                  mul_a     <= MW'(r2);
                  mul_b     <= MW'(l2);
                  op        <= OP_RL;
                  mul_start <= 1'b1;
                end
              end
              OP_RL: begin
                sqrt_rad   <= rl_sub;
                sqrt_start <= 1'b1;
                kk         <= 1'b0;
                state      <= ST_SQRT_S;
              end
              OP_TLO: begin
                // numerator below zero: keep only inside the slack, t clamps to 0
                if (n_sh > mul_p) begin
                  state <= ST_NEXT;
                end else begin
                  t         <= '0;
                  mul_a     <= MW'(len);
                  mul_b     <= '0;
                  op        <= OP_ARC;
                  mul_start <= 1'b1;
                end
              end
              OP_THI: begin
                if (n_sh > mul_p) begin
                  state <= ST_NEXT;
                end else if (n[68:0] >= 69'(l2)) begin
                  t         <= T_ONE;
                  mul_a     <= MW'(len);
                  mul_b     <= MW'(T_ONE);
                  op        <= OP_ARC;
                  mul_start <= 1'b1;
                end else begin
                  t       <= '0;
                  div_rem <= n[66:0];
                  div_cnt <= DCW'(FRAC_BITS);
                  state   <= ST_DIV;
                end
              end
              OP_ARC: begin
                arc       <= arc_sum[AW] ? {AW{1'b1}} : arc_sum[AW-1:0];
                mul_a     <= MW'(mag33(dx));
                mul_b     <= MW'(t);
                mul_neg   <= dx[32];
                op        <= OP_PX;
                mul_start <= 1'b1;
              end
              OP_PX: begin
                px        <= lerp_sum[31:0];
                mul_a     <= MW'(mag33(dy));
                mul_b     <= MW'(t);
                mul_neg   <= dy[32];
                op        <= OP_PY;
                mul_start <= 1'b1;
              end
              OP_PY: begin
                py        <= lerp_sum[31:0];
                mul_a     <= MW'(mag33(dz));
                mul_b     <= MW'(t);
                mul_neg   <= dz[32];
                op        <= OP_PZ;
                mul_start <= 1'b1;
              end
              OP_PZ: begin
                pz    <= lerp_sum[31:0];
                state <= ST_MERGE;
              end
              OP_QX: begin
                d2        <= mul_p[67:0];
                mul_a     <= MW'(mag33(qy));
                mul_b     <= MW'(mag33(qy));
                op        <= OP_QY;
                mul_start <= 1'b1;
              end
              OP_QY: begin
                d2        <= d2_sum;
                mul_a     <= MW'(mag33(qz));
                mul_b     <= MW'(mag33(qz));
                op        <= OP_QZ;
                mul_start <= 1'b1;
              end
              OP_QZ: begin
                state <= (d2_sum <= 68'(merge_dist_sq)) ? ST_NEXT : ST_KEEP;
              end
              default: state <= ST_DONE;
            endcase
          end
        end

        ST_SQRT_LEN: begin
          if (sqrt_done) begin
            len <= sqrt_root[33:0];
            // zero ground length: counted, no crossings
            if (dx == '0 && dz == '0) begin
              state <= ST_DONE;
            end else begin
              mul_a     <= MW'(mag33(ox));
              mul_b     <= MW'(mag33(dx));
              mul_neg   <= ox[32] ^ dx[32];
              op        <= OP_DOTX;
              mul_start <= 1'b1;
              state     <= ST_MUL;
            end
          end
        end

        ST_SQRT_S: begin
          if (sqrt_done) begin
            sq    <= sqrt_root;
            state <= ST_CAND;
          end
        end

        ST_CAND: begin
          // near crossing first, then far crossing
          n         <= n_cand;
          mul_a     <= n_cand[69] ? MW'(edge_slack) : MW'(T_ONE) + MW'(edge_slack);
          mul_b     <= MW'(l2);
          mul_neg   <= 1'b0;
          op        <= n_cand[69] ? OP_TLO : OP_THI;
          mul_start <= 1'b1;
          state     <= ST_MUL;
        end

        ST_DIV: begin
          div_rem <= div_ge ? rem_sh - 67'(l2) : rem_sh;
          t       <= t_div;
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == DCW'(1)) begin
            mul_a     <= MW'(len);
            mul_b     <= MW'(t_div);
            op        <= OP_ARC;
            mul_start <= 1'b1;
            state     <= ST_MUL;
          end
        end

        ST_MERGE: begin
          if (!prev_hit_valid) begin
            state <= ST_KEEP;
          end else if (da <= AW'(arc_tolerance)) begin
            state <= ST_NEXT;
          end else begin
            mul_a     <= MW'(mag33(qx));
            mul_b     <= MW'(mag33(qx));
            mul_neg   <= 1'b0;
            op        <= OP_QX;
            mul_start <= 1'b1;
            state     <= ST_MUL;
          end
        end

        ST_KEEP: begin
          prev_hit_valid <= 1'b1;
          prev_hit_arc   <= arc;
          prev_hit_x     <= px;
          prev_hit_y     <= py;
          prev_hit_z     <= pz;
          if (pend) begin
            // earlier hit of this segment goes out first, not last
            out_valid   <= 1'b1;
            last_of_run <= 1'b0;
            state       <= ST_EMIT;
          end else begin
            hit_curve   <= curve_id;
            hit_segment <= segment_count;
            hit_t       <= t;
            hit_arc     <= arc;
            hit_x       <= px;
            hit_y       <= py;
            hit_z       <= pz;
            pend        <= 1'b1;
            state       <= ST_NEXT;
          end
        end

        ST_EMIT: begin
          if (out_take) begin
            out_valid   <= 1'b0;
            hit_curve   <= curve_id;
            hit_segment <= segment_count;
            hit_t       <= t;
            hit_arc     <= arc;
            hit_x       <= px;
            hit_y       <= py;
            hit_z       <= pz;
            state       <= ST_NEXT;
          end
        end

        ST_NEXT: begin
          if (!kk) begin
            kk    <= 1'b1;
            state <= ST_CAND;
          end else begin
            state <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (pend) begin
            out_valid   <= 1'b1;
            last_of_run <= 1'b1;
            state       <= ST_FLUSH;
          end else begin
            arc_prefix    <= pre_sum[AW] ? {AW{1'b1}} : pre_sum[AW-1:0];
            segment_count <= segment_count + 1'b1;
            state         <= ST_IDLE;
          end
        end

        ST_FLUSH: begin
          if (out_take) begin
            out_valid     <= 1'b0;
            pend          <= 1'b0;
            arc_prefix    <= pre_sum[AW] ? {AW{1'b1}} : pre_sum[AW-1:0];
            segment_count <= segment_count + 1'b1;
            state         <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
